>>> rtl/vafd_pkg.sv
// ----------------------------------------------------------------------------
// vafd_pkg
// Shared types and constants of the vertex attribute fetch and decode block.
// ----------------------------------------------------------------------------
package vafd_pkg;

  localparam int unsigned MaxLanes = 4;

  // component type codes
  localparam logic [2:0] CT_BYTE   = 3'd0;
  localparam logic [2:0] CT_UBYTE  = 3'd1;
  localparam logic [2:0] CT_SHORT  = 3'd2;
  localparam logic [2:0] CT_USHORT = 3'd3;
  localparam logic [2:0] CT_UINT32 = 3'd4;
  localparam logic [2:0] CT_FLOAT  = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_COMP_TYPE  = 3'd0;
  localparam logic [2:0] REG_ACC_WIDTH  = 3'd1;
  localparam logic [2:0] REG_WANTED     = 3'd2;
  localparam logic [2:0] REG_NORM       = 3'd3;
  localparam logic [2:0] REG_BASE       = 3'd4;
  localparam logic [2:0] REG_STRIDE     = 3'd5;
  localparam logic [2:0] REG_BUF_BYTES  = 3'd6;
  localparam logic [2:0] REG_ELEM_COUNT = 3'd7;

  localparam logic [31:0] OneBits = 32'h3F80_0000;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SHAPE = 3'd1,
    ST_RANGE     = 3'd2,
    ST_BAD_TYPE  = 3'd3,
    ST_OOB       = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]  comp_type;
    logic [2:0]  acc_width;
    logic [2:0]  wanted;
    logic        norm;
    logic [31:0] base;
    logic [7:0]  stride;
    logic [31:0] buf_bytes;
    logic [31:0] elem_count;
  } cfg_t;

endpackage

>>> rtl/vafd_lane.sv
// ----------------------------------------------------------------------------
// vafd_lane
// One component decoder: integer or normalized integer to float32, other types passed through, two steps.
// ----------------------------------------------------------------------------
module vafd_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] raw_i,
  input  logic [2:0]  comp_type_i,
  input  logic        norm_i,
  output logic [31:0] bits_o
);
  import vafd_pkg::*;

  typedef enum logic [1:0] {K_PASS, K_INT, K_NORM, K_ONE} kind_e;

  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  kind_e       kind_d, kind_q;
  logic        neg_d, neg_q;
  logic [31:0] mag_d, mag_q;
  logic [4:0]  lz_d, lz_q;
  logic [1:0]  sub_q;
  logic [16:0] div_c;
  logic [5:0]  lz16;
  logic [5:0]  lz32;
  logic [4:0]  pw;

  // first step: sign, magnitude and leading-zero count
  always_comb begin
    neg_d = 1'b0;
    mag_d = raw_i;
    div_c = 17'd255;
    pw    = 5'd8;
    case (comp_type_i)
      CT_BYTE: begin
        neg_d = raw_i[7];
        mag_d = {24'b0, raw_i[7] ? 8'(-raw_i[7:0]) : raw_i[7:0]};
        div_c = 17'd127;
        pw    = 5'd7;
      end
      CT_UBYTE: begin
        mag_d = {24'b0, raw_i[7:0]};
      end
      CT_SHORT: begin
        neg_d = raw_i[15];
        mag_d = {16'b0, raw_i[15] ? 16'(-raw_i[15:0]) : raw_i[15:0]};
        div_c = 17'd32767;
        pw    = 5'd15;
      end
      CT_USHORT: begin
        mag_d = {16'b0, raw_i[15:0]};
        div_c = 17'd65535;
        pw    = 5'd16;
      end
      default: ;
    endcase
    lz16 = lzc32({mag_d[15:0], 16'hFFFF});
    lz32 = lzc32(mag_d);
    if (comp_type_i > CT_UINT32) begin
      kind_d = K_PASS;
      lz_d   = '0;
    end else if (norm_i && comp_type_i != CT_UINT32) begin
      kind_d = (mag_d[16:0] >= div_c) ? K_ONE : K_NORM;
      // leading zeros within the period of the repeated fraction
      lz_d   = 5'(lz16) - (5'd16 - pw);
    end else begin
      kind_d = K_INT;
      lz_d   = lz32[4:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q <= kind_d;
      neg_q  <= neg_d;
      mag_q  <= mag_d;
      lz_q   <= lz_d;
      sub_q  <= comp_type_i[1:0];
    end
  end

  // second step: normalize, round, pack
  logic [31:0] ishift;
  logic [30:0] ipack;
  logic [63:0] frac, nshift;
  logic [30:0] npack;

  always_comb begin
    ishift = mag_q << lz_q;
    ipack  = {8'(8'd158 - {3'b0, lz_q}), ishift[30:8]}
           + 31'(ishift[7] & ((|ishift[6:0]) | ishift[8]));
    // b/(2^p-1) is b repeated forever, so the tail past the round bit is never zero
    case (sub_q)
      2'd0:    frac = {mag_q[6:0], mag_q[6:0], mag_q[6:0], mag_q[6:0], mag_q[6:0],
                       mag_q[6:0], mag_q[6:0], mag_q[6:0], mag_q[6:0], mag_q[6:6]};
      2'd1:    frac = {8{mag_q[7:0]}};
      2'd2:    frac = {mag_q[14:0], mag_q[14:0], mag_q[14:0], mag_q[14:0],
                       mag_q[14:11]};
      default: frac = {4{mag_q[15:0]}};
    endcase
    nshift = frac << lz_q[3:0];
    npack  = {8'(8'd126 - {3'b0, lz_q}), nshift[62:40]} + 31'(nshift[39]);
    case (kind_q)
      K_PASS:  bits_o = mag_q;
      K_ONE:   bits_o = {neg_q, OneBits[30:0]};
      K_INT:   bits_o = (mag_q == '0) ? '0 : {neg_q, ipack};
      default: bits_o = (mag_q == '0) ? '0 : {neg_q, npack};
    endcase
  end

endmodule

>>> rtl/vafd_addr.sv
// ----------------------------------------------------------------------------
// vafd_addr
// Element address and accessor checks, two steps.
// ----------------------------------------------------------------------------
module vafd_addr (
  input  logic                clk_i,
  input  logic                en_i,
  input  vafd_pkg::cfg_t      cfg_i,
  input  logic [31:0]         idx_i,
  output logic [39:0]         addr_o,
  output vafd_pkg::status_e   status_o
);
  import vafd_pkg::*;

  logic [2:0]  csize;
  logic [4:0]  req_d, req_q;
  logic [7:0]  stride;
  logic [39:0] prod_q;
  status_e     st_d, st_q;

  always_comb begin
    csize  = (cfg_i.comp_type < CT_SHORT) ? 3'd1 :
             (cfg_i.comp_type < CT_UINT32) ? 3'd2 : 3'd4;
    req_d  = {2'b0, csize} * {2'b0, cfg_i.acc_width};
    stride = (cfg_i.stride != '0) ? cfg_i.stride : {3'b0, req_d};
    if (cfg_i.acc_width == '0 || cfg_i.acc_width > 3'd4) begin
      st_d = ST_BAD_SHAPE;
    end else if (cfg_i.wanted > cfg_i.acc_width || idx_i >= cfg_i.elem_count) begin
      st_d = ST_RANGE;
    end else if (cfg_i.comp_type > CT_FLOAT) begin
      st_d = ST_BAD_TYPE;
    end else begin
      st_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= idx_i * stride;
      req_q  <= req_d;
      st_q   <= st_d;
    end
  end

  logic [40:0] addr, room;

  always_comb begin
    addr = {9'b0, cfg_i.base} + {1'b0, prod_q};
    room = {9'b0, cfg_i.buf_bytes} - addr;
    if (st_q != ST_OK) begin
      status_o = st_q;
      addr_o   = '0;
    end else begin
      addr_o   = addr[39:0];
      status_o = (addr > {9'b0, cfg_i.buf_bytes} || {36'b0, req_q} > room)
               ? ST_OOB : ST_OK;
    end
  end

endmodule

>>> rtl/vertex_attribute_fetch_decode_core.sv
// ----------------------------------------------------------------------------
// vertex_attribute_fetch_decode_core
// Fetch address, checks and float32 decode of one vertex attribute element.
// ----------------------------------------------------------------------------
// channel   signals                             direction
// in        in_valid_i / in_ready_o, payload    request in
// out       out_valid_o / out_ready_i, payload  result out
// cfg       cfg_we_i, cfg_idx_i, cfg_data_i     register write
//
// one pipeline step plus the output register: a request passes the step register,
// then the output register; one request per cycle while the output is not stalled.
// the address multiply and the lane leading-zero counts sit in the first step,
// rounding and bounds compare in front of the output register.
// a stalled output holds the pipeline; ready looks ahead at the output.
// reset loads the register defaults and empties the pipeline.
module vertex_attribute_fetch_decode_core #(
  parameter int unsigned LANES = vafd_pkg::MaxLanes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] element_index_i,
  input  logic [63:0] raw_low_i,
  input  logic [63:0] raw_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [39:0] byte_address_o,
  output logic [2:0]  status_o,
  output logic [31:0] lane_x_o,
  output logic [31:0] lane_y_o,
  output logic [31:0] lane_z_o,
  output logic [31:0] lane_w_o
);
  import vafd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{comp_type: CT_FLOAT, acc_width: 3'd3, wanted: 3'd3, norm: 1'b0,
                 base: '0, stride: '0, buf_bytes: '0, elem_count: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COMP_TYPE:  cfg_q.comp_type  <= cfg_data_i[2:0];
        REG_ACC_WIDTH:  cfg_q.acc_width  <= cfg_data_i[2:0];
        REG_WANTED:     cfg_q.wanted     <= cfg_data_i[2:0];
        REG_NORM:       cfg_q.norm       <= cfg_data_i[0];
        REG_BASE:       cfg_q.base       <= cfg_data_i;
        REG_STRIDE:     cfg_q.stride     <= cfg_data_i[7:0];
        REG_BUF_BYTES:  cfg_q.buf_bytes  <= cfg_data_i;
        REG_ELEM_COUNT: cfg_q.elem_count <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic s1_v_q, out_v_q, adv1, adv2, accept;

  assign adv2       = !out_v_q || out_ready_i;
  assign adv1       = !s1_v_q || adv2;
  assign in_ready_o = adv1;
  assign accept     = in_valid_i && adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q  <= in_valid_i;
      if (adv2) out_v_q <= s1_v_q;
    end
  end

  // lane slicing of the raw bytes by component size
  logic [127:0] raw;
  logic [31:0]  lane_raw  [MaxLanes];
  logic [31:0]  lane_bits [MaxLanes];
  logic [MaxLanes-1:0] lane_en;

  assign raw = {raw_high_i, raw_low_i};

  for (genvar g = 0; g < MaxLanes; g++) begin : g_lane
    always_comb begin
      if (cfg_q.comp_type < CT_SHORT) begin
        lane_raw[g] = {24'b0, raw[8*g +: 8]};
      end else if (cfg_q.comp_type < CT_UINT32) begin
        lane_raw[g] = {16'b0, raw[16*g +: 16]};
      end else begin
        lane_raw[g] = raw[32*g +: 32];
      end
    end
    if (g < LANES) begin : g_on
      vafd_lane u_lane (
        .clk_i       (clk_i),
        .en_i        (accept),
        .raw_i       (lane_raw[g]),
        .comp_type_i (cfg_q.comp_type),
        .norm_i      (cfg_q.norm),
        .bits_o      (lane_bits[g])
      );
      assign lane_en[g] = (3'(g) < cfg_q.wanted);
    end else begin : g_off
      assign lane_bits[g] = '0;
      assign lane_en[g]   = 1'b0;
    end
  end

  logic [39:0] addr;
  status_e     status;

  vafd_addr u_addr (
    .clk_i    (clk_i),
    .en_i     (accept),
    .cfg_i    (cfg_q),
    .idx_i    (element_index_i),
    .addr_o   (addr),
    .status_o (status)
  );

  // merge: checks gate the lanes, absent lanes take defaults
  logic [31:0] lane_d [MaxLanes];

  always_comb begin
    for (int i = 0; i < MaxLanes; i++) begin
      if (status == ST_OK && lane_en[i]) begin
        lane_d[i] = lane_bits[i];
      end else begin
        lane_d[i] = (i == MaxLanes - 1) ? OneBits : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_v_q) begin
      byte_address_o <= addr;
      status_o       <= status;
      lane_x_o       <= lane_d[0];
      lane_y_o       <= lane_d[1];
      lane_z_o       <= lane_d[2];
      lane_w_o       <= lane_d[3];
    end
  end

  assign out_valid_o = out_v_q;

`ifndef SYNTHESIS
  a_err_lanes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (lane_w_o == OneBits && lane_x_o == '0))
    else $error("error result carries decoded lanes");

  a_err_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_BAD_SHAPE || status_o == ST_RANGE ||
     status_o == ST_BAD_TYPE)) |-> (byte_address_o == '0))
    else $error("check failure with nonzero address");

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !adv2) |=> s1_v_q)
    else $error("pipeline step dropped a request under stall");

  a_no_accept_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_v_q && !out_ready_i) |-> !in_ready_o)
    else $error("request taken while pipeline is full");
`endif

endmodule

>>> bench/vertex_attribute_fetch_decode_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_attribute_fetch_decode_core_tb
// Drives element requests under changing accessor settings and compares each
// decoded element against a float32 decode worked out inside the bench.
// ----------------------------------------------------------------------------
module vertex_attribute_fetch_decode_core_tb;
  import vafd_pkg::*;

  typedef struct {
    logic [31:0] idx;
    logic [63:0] lo;
    logic [63:0] hi;
  } fetch_t;

  typedef struct {
    logic [39:0] addr;
    status_e     status;
    logic [31:0] lane [4];
  } element_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = REG_COMP_TYPE;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] element_index_i = '0;
  logic [63:0] raw_low_i = '0;
  logic [63:0] raw_high_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [39:0] byte_address_o;
  logic [2:0]  status_o;
  logic [31:0] lane_x_o, lane_y_o, lane_z_o, lane_w_o;

  fetch_t   fetch_q [$];
  element_t decoded_q [$];
  cfg_t     shadow;
  int       errors = 0;
  bit       in_fire = 0;
  bit       gaps_on = 1;
  int       tx_gap = 0;
  int       rx_gap = 0;
  int       rx_hold = 0;

  vertex_attribute_fetch_decode_core u_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // double to float32 with round to nearest even, normal range only
  function automatic logic [31:0] to_f32(real v);
    logic [63:0] d;
    logic [52:0] m;
    logic [24:0] q;
    logic [28:0] rest;
    int          e;
    d = $realtobits(v);
    if (d[62:0] == '0) return {d[63], 31'd0};
    m = {1'b1, d[51:0]};
    q = {1'b0, m[52:29]};
    rest = m[28:0];
    e = int'(d[62:52]) - 1023 + 127;
    if (rest > 29'h1000_0000 || (rest == 29'h1000_0000 && q[0])) q = q + 1;
    if (q[24]) begin
      q = q >> 1;
      e = e + 1;
    end
    return {d[63], e[7:0], q[22:0]};
  endfunction

  function automatic logic [31:0] decode_comp(logic [31:0] c);
    real    v;
    int     sv;
    longint lv;
    case (shadow.comp_type)
      CT_BYTE: begin
        sv = $signed(c[7:0]);
        v = sv;
        if (shadow.norm) v = v / 127.0;
      end
      CT_UBYTE: begin
        sv = c[7:0];
        v = sv;
        if (shadow.norm) v = v / 255.0;
      end
      CT_SHORT: begin
        sv = $signed(c[15:0]);
        v = sv;
        if (shadow.norm) v = v / 32767.0;
      end
      CT_USHORT: begin
        sv = c[15:0];
        v = sv;
        if (shadow.norm) v = v / 65535.0;
      end
      CT_UINT32: begin
        lv = c;
        v = lv;
      end
      default: return c;
    endcase
    // only normalized signed values are clamped
    if (shadow.norm && v < -1.0) v = -1.0;
    return to_f32(v);
  endfunction

  function automatic element_t decode_element(fetch_t f);
    element_t    r;
    logic [127:0] raw;
    longint unsigned sz, required, stride, addr;
    raw = {f.hi, f.lo};
    r.addr = '0;
    r.status = ST_OK;
    r.lane[0] = '0;
    r.lane[1] = '0;
    r.lane[2] = '0;
    r.lane[3] = OneBits;
    sz = 0;
    if (shadow.acc_width == 0 || shadow.acc_width > 4) begin
      r.status = ST_BAD_SHAPE;
    end else if (shadow.wanted > shadow.acc_width || f.idx >= shadow.elem_count) begin
      r.status = ST_RANGE;
    end else if (shadow.comp_type > CT_FLOAT) begin
      r.status = ST_BAD_TYPE;
    end else begin
      sz = (shadow.comp_type < CT_SHORT) ? 1 : (shadow.comp_type < CT_UINT32) ? 2 : 4;
      required = sz * shadow.acc_width;
      stride = (shadow.stride != 0) ? longint'(shadow.stride) : required;
      addr = longint'(shadow.base) + longint'(f.idx) * stride;
      if (addr > shadow.buf_bytes || required > longint'(shadow.buf_bytes) - addr)
        r.status = ST_OOB;
      r.addr = addr[39:0];
    end
    if (r.status == ST_OK) begin
      for (int i = 0; i < shadow.wanted && i < MaxLanes; i++)
        r.lane[i] = decode_comp(32'((raw >> (i * sz * 8)) &
                                    ((128'd1 << (sz * 8)) - 1)));
    end
    return r;
  endfunction

  task automatic report(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request side
  always @(negedge clk_i) begin
    fetch_t f;
    if (!in_valid_i || in_fire) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (fetch_q.size() > 0) begin
        f = fetch_q.pop_front();
        element_index_i <= f.idx;
        raw_low_i <= f.lo;
        raw_high_i <= f.hi;
        in_valid_i <= 1'b1;
        tx_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side, with an optional long hold-off
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      rx_gap = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    fetch_t   f;
    element_t e;
    in_fire = in_valid_i && in_ready_o;
    if (in_fire) begin
      f.idx = element_index_i;
      f.lo = raw_low_i;
      f.hi = raw_high_i;
      decoded_q.insert(decoded_q.size(), decode_element(f));
    end
    if (out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        report("unexpected result", byte_address_o, '0);
      end else begin
        e = decoded_q.pop_front();
        if (byte_address_o !== e.addr) report("byte_address", byte_address_o, e.addr);
        if (status_o !== e.status) report("status", status_o, e.status);
        if (lane_x_o !== e.lane[0]) report("lane_x", lane_x_o, e.lane[0]);
        if (lane_y_o !== e.lane[1]) report("lane_y", lane_y_o, e.lane[1]);
        if (lane_z_o !== e.lane[2]) report("lane_z", lane_z_o, e.lane[2]);
        if (lane_w_o !== e.lane[3]) report("lane_w", lane_w_o, e.lane[3]);
      end
    end
  end

  task automatic drain();
    while (fetch_q.size() > 0 || in_valid_i || decoded_q.size() > 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_cfg(cfg_t c);
    drain();
    write_reg(REG_COMP_TYPE, 32'(c.comp_type));
    write_reg(REG_ACC_WIDTH, 32'(c.acc_width));
    write_reg(REG_WANTED, 32'(c.wanted));
    write_reg(REG_NORM, 32'(c.norm));
    write_reg(REG_BASE, c.base);
    write_reg(REG_STRIDE, 32'(c.stride));
    write_reg(REG_BUF_BYTES, c.buf_bytes);
    write_reg(REG_ELEM_COUNT, c.elem_count);
    shadow = c;
  endtask

  task automatic push_fetch(logic [31:0] idx, logic [63:0] lo, logic [63:0] hi);
    fetch_t f;
    f.idx = idx;
    f.lo = lo;
    f.hi = hi;
    fetch_q.insert(fetch_q.size(), f);
  endtask

  function automatic cfg_t roomy_cfg(logic [2:0] ct, logic [2:0] w, logic [2:0] want,
                                     logic nm);
    cfg_t c;
    c.comp_type = ct;
    c.acc_width = w;
    c.wanted = want;
    c.norm = nm;
    c.base = 32'd16;
    c.stride = 8'd0;
    c.buf_bytes = 32'h0010_0000;
    c.elem_count = 32'd1000;
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    longint unsigned span;
    c.comp_type = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
    c.acc_width = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
    c.wanted = ($urandom_range(0, 9) == 0) ? 3'($urandom)
             : 3'($urandom_range(0, (c.acc_width >= 1 && c.acc_width <= 4) ?
                                    c.acc_width : 4));
    c.norm = 1'($urandom);
    c.stride = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      c.base = $urandom;
      c.buf_bytes = $urandom;
      c.elem_count = $urandom;
    end else begin
      c.base = $urandom_range(0, 4096);
      c.elem_count = $urandom_range(1, 200);
      span = longint'(c.base) + longint'(c.elem_count) * 256 + $urandom_range(0, 64);
      c.buf_bytes = ($urandom_range(0, 3) == 0) ? 32'(span / 2) : 32'(span);
    end
    return c;
  endfunction

  function automatic logic [63:0] random_raw();
    case ($urandom_range(0, 5))
      0: return {8{8'(8'h7F + $urandom_range(0, 1))}};
      1: return {4{16'(16'h7FFF + $urandom_range(0, 2))}};
      2: return {$urandom, $urandom} | 64'hFFFF_0000_FF00_FF00;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    cfg_t c;
    int   n;
    logic [31:0] idx;
    shadow = '{comp_type: CT_FLOAT, acc_width: 3'd3, wanted: 3'd3, norm: 1'b0,
               base: '0, stride: '0, buf_bytes: '0, elem_count: '0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: no elements, so range status
    push_fetch(32'd0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);

    // every component type, normalized for even type codes, extreme patterns
    for (int t = CT_BYTE; t <= CT_FLOAT; t++) begin
      load_cfg(roomy_cfg(3'(t), 3'd4, 3'd4, 1'(t % 2 == 0)));
      push_fetch(32'd0, 64'h8000_7FFF_FF01_807F, 64'hFFFF_FFFF_0000_0000);
      push_fetch(32'd999, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    end
    load_cfg(roomy_cfg(CT_SHORT, 3'd4, 3'd4, 1'b0));
    push_fetch(32'd1, 64'h0000_0000_0000_0000, 64'h0);

    // bad shape, too many wanted, zero wanted, unsupported type
    load_cfg(roomy_cfg(CT_UBYTE, 3'd0, 3'd1, 1'b0));
    push_fetch(32'd2, 64'h1, 64'h0);
    load_cfg(roomy_cfg(CT_UBYTE, 3'd7, 3'd1, 1'b0));
    push_fetch(32'd2, 64'h1, 64'h0);
    load_cfg(roomy_cfg(CT_USHORT, 3'd2, 3'd3, 1'b1));
    push_fetch(32'd2, 64'h1, 64'h0);
    load_cfg(roomy_cfg(CT_USHORT, 3'd2, 3'd0, 1'b1));
    push_fetch(32'd3, 64'hFFFF, 64'h0);
    load_cfg(roomy_cfg(3'd7, 3'd2, 3'd2, 1'b0));
    push_fetch(32'd3, 64'hFFFF, 64'h0);

    // bounds edge: element ends exactly at the buffer end, then one byte short
    c = roomy_cfg(CT_UINT32, 3'd4, 3'd4, 1'b0);
    c.base = 32'd100;
    c.stride = 8'd20;
    c.buf_bytes = 32'd100 + 32'd20 * 5 + 32'd16;
    load_cfg(c);
    push_fetch(32'd5, 64'hDEAD_BEEF_0000_0001, 64'h8000_0000_FFFF_FFFF);
    push_fetch(32'd6, 64'h1, 64'h2);
    c.buf_bytes = c.buf_bytes - 1;
    load_cfg(c);
    push_fetch(32'd5, 64'h1, 64'h2);

    // extreme address
    c = roomy_cfg(CT_FLOAT, 3'd4, 3'd4, 1'b1);
    c.base = 32'hFFFF_FFFF;
    c.stride = 8'hFF;
    c.buf_bytes = 32'hFFFF_FFFF;
    c.elem_count = 32'hFFFF_FFFF;
    load_cfg(c);
    push_fetch(32'hFFFF_FFFE, 64'h7FC0_0001_FF80_0000, 64'h0);
    push_fetch(32'd0, 64'h0, 64'h0);

    // random phases
    for (int ph = 0; ph < 32; ph++) begin
      c = random_cfg();
      load_cfg(c);
      gaps_on = (ph % 5 != 3);
      if (ph == 7) begin
        gaps_on = 0;
        rx_hold = 80;
      end
      n = $urandom_range(40, 75);
      for (int k = 0; k < n; k++) begin
        if (c.elem_count != 0 && $urandom_range(0, 9) != 0)
          idx = $urandom % c.elem_count;
        else
          idx = $urandom;
        push_fetch(idx, random_raw(), random_raw());
      end
    end
    gaps_on = 1;
    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
